@@ sv/sdbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbc_pkg
// Shared constants for the signed decimal / binary converter.
// ----------------------------------------------------------------------------
package sdbc_pkg;

	localparam int RES_W           = 128;
	localparam int HALF_W          = 64;
	localparam int DIGIT_W         = 4;
	localparam int DEF_VALUE_WIDTH = 128;

	localparam logic OP_TO_BIN = 1'b0;
	localparam logic OP_TO_DEC = 1'b1;

	localparam logic KIND_BIN  = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

endpackage

@@ sv/signed_decimal_binary_converter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_binary_converter_unit
// Decimal digits to two's complement and back; a shift/add-3 unit converts to decimal.
// ----------------------------------------------------------------------------
// Digit item (op 0): take, then accumulate; a final digit then loads its binary
// result, which waits while out_ready is low.
// Value item (op 1): take, negate, double-dabble over all VALUE_WIDTH bits,
// emit a minus sign if negative, skip leading zeros, then emit one character per
// digit; each character also waits while out_ready is low.
// in_ready is high only in idle; reset clears sequencer, entry flags and out valid.
// ----------------------------------------------------------------------------
module signed_decimal_binary_converter_unit
	import sdbc_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [DIGIT_W-1:0]  digit,
	input  logic                negative,
	input  logic                final_digit,
	input  logic [HALF_W-1:0]   value_high,
	input  logic [HALF_W-1:0]   value_low,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [HALF_W-1:0]   result_high,
	output logic [HALF_W-1:0]   result_low,
	output logic                overflow,
	output logic [DIGIT_W-1:0]  out_digit,
	output logic                is_minus,
	output logic                last
);

	localparam int W     = VALUE_WIDTH;
	localparam int FW    = W + 4;
	localparam int ND    = (W * 1233) / 4096 + 1;
	localparam int BCD_W = DIGIT_W * ND;
	localparam int BW    = $clog2(W);
	localparam int CW    = $clog2(ND + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DACC,
		S_DRES,
		S_PNEG,
		S_PDAB,
		S_PMINUS,
		S_PSKIP,
		S_PEMIT
	} state_t;

	state_t              state_q;
	logic [W-1:0]        acc_q;
	logic                sign_q;
	logic                ovf_q;
	logic                await_q;
	logic [DIGIT_W-1:0]  dig_q;
	logic                fin_q;
	logic                neg_in_q;
	logic [W-1:0]        sh_q;
	logic                neg_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BW-1:0]       bit_q;
	logic [CW-1:0]       cnt_q;

	logic                out_valid_q;
	logic                kind_q;
	logic [RES_W-1:0]    res_q;
	logic                ovf_out_q;
	logic [DIGIT_W-1:0]  odig_q;
	logic                minus_q;
	logic                last_q;

	logic                out_free;
	logic                out_load;
	logic [W-1:0]        acc_b;
	logic                ovf_b;
	logic                sign_b;
	logic [FW-1:0]       f;
	logic [4:0]          f_top;
	logic                f_ge;
	logic                f_gt;
	logic                ovf_new;
	logic [W-1:0]        res_mag;
	logic signed [W-1:0] res_s;
	logic [RES_W-1:0]    res_ext;
	logic [RES_W-1:0]    val_in;
	logic [BCD_W-1:0]    bcd_adj;
	logic [DIGIT_W-1:0]  top_dig;

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_DRES) || (state_q == S_PMINUS) ||
		(state_q == S_PEMIT));
	assign in_ready = (state_q == S_IDLE);

	// digit accumulate: acc * 10 + digit, with range check on the full sum
	assign acc_b  = await_q ? '0 : acc_q;
	assign ovf_b  = await_q ? 1'b0 : ovf_q;
	assign sign_b = await_q ? neg_in_q : sign_q;
	assign f      = FW'({acc_b, 3'b000}) + FW'({acc_b, 1'b0}) + FW'(dig_q);
	assign f_top  = f[FW-1:W-1];
	assign f_ge   = |f_top;
	assign f_gt   = f_ge && !((f_top == 5'd1) && (f[W-2:0] == '0));
	assign ovf_new = ovf_b || (sign_b ? f_gt : f_ge);

	assign res_mag = sign_q ? (~acc_q + W'(1)) : acc_q;
	assign res_s   = res_mag;
	assign res_ext = RES_W'(res_s);

	assign val_in  = {value_high, value_low};
	assign top_dig = bcd_q[BCD_W-1 -: DIGIT_W];

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
				bcd_adj[DIGIT_W*i +: DIGIT_W] = bcd_q[DIGIT_W*i +: DIGIT_W] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			sign_q      <= 1'b0;
			ovf_q       <= 1'b0;
			await_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dig_q    <= digit;
						fin_q    <= final_digit;
						neg_in_q <= negative;
						sh_q     <= val_in[W-1:0];
						state_q  <= (op == OP_TO_DEC) ? S_PNEG : S_DACC;
					end
				end
				S_DACC: begin
					acc_q   <= f[W-1:0];
					ovf_q   <= ovf_new;
					sign_q  <= sign_b;
					await_q <= 1'b0;
					state_q <= fin_q ? S_DRES : S_IDLE;
				end
				S_DRES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_BIN;
						res_q       <= res_ext;
						ovf_out_q   <= ovf_q;
						odig_q      <= '0;
						minus_q     <= 1'b0;
						last_q      <= 1'b1;
						await_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PNEG: begin
					neg_q <= sh_q[W-1];
					if (sh_q[W-1]) begin
						sh_q <= ~sh_q + W'(1);
					end
					bcd_q   <= '0;
					bit_q   <= BW'(W - 1);
					state_q <= S_PDAB;
				end
				S_PDAB: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[W-1]};
					sh_q  <= {sh_q[W-2:0], 1'b0};
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						cnt_q   <= CW'(ND);
						state_q <= neg_q ? S_PMINUS : S_PSKIP;
					end
				end
				S_PMINUS: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_CHAR;
						res_q       <= '0;
						ovf_out_q   <= 1'b0;
						odig_q      <= '0;
						minus_q     <= 1'b1;
						last_q      <= 1'b0;
						state_q     <= S_PSKIP;
					end
				end
				S_PSKIP: begin
					if ((top_dig == '0) && (cnt_q > CW'(1))) begin
						bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						cnt_q <= cnt_q - CW'(1);
					end else begin
						state_q <= S_PEMIT;
					end
				end
				S_PEMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_CHAR;
						res_q       <= '0;
						ovf_out_q   <= 1'b0;
						odig_q      <= top_dig;
						minus_q     <= 1'b0;
						last_q      <= (cnt_q == CW'(1));
						bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign result_high = res_q[RES_W-1:HALF_W];
	assign result_low  = res_q[HALF_W-1:0];
	assign overflow    = ovf_out_q;
	assign out_digit   = odig_q;
	assign is_minus    = minus_q;
	assign last        = last_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while one is in work");

	a_bin_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BIN) |-> last && !is_minus && (out_digit == '0))
		else $error("binary result with character fields set");

	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CHAR) |->
			(result_high == '0) && (result_low == '0) && !overflow)
		else $error("character result with binary fields set");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_minus |-> !last && (kind == KIND_CHAR))
		else $error("minus sign marked as final character");

endmodule
